FILE: src/nnis_pkg.sv
// Shared types and constants for the nearest-neighbor image scaler.
// No dependencies; nnis_div and the top level import this package.
`timescale 1ns / 1ps

package nnis_pkg;

  // default frame store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // field widths
  localparam int COORD_W = 12;
  localparam int PIX_W   = 32;
  localparam int SIZE_W  = 9;
  localparam int SCALE_W = 12;
  localparam int BPP_W   = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 12;

  // scale limits, Q4.8, and saturation of the reported frame size
  localparam int SCALE_MIN = 26;
  localparam int SCALE_MAX = 2560;
  localparam int SIZE_SAT  = 4095;
  localparam int FRAC_W    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 8'd3;

  // divider: (coord << 8) / scale, one quotient bit per cycle
  localparam int DVD_W = COORD_W + FRAC_W;
  localparam int DSR_W = SCALE_W;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/nnis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/nnis_div.sv
// Restoring divider, one quotient bit per cycle, shared by both coordinates.
// Depends on nnis_pkg.
`timescale 1ns / 1ps

module nnis_div (
  input  logic               clk,
  input  logic               rst,
  input  nnis_pkg::div_req_t req,
  output nnis_pkg::div_rsp_t rsp
);

  import nnis_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;      // dividend shifts out, quotient shifts in
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] diff;
  logic             fits;

  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    fits    = !diff[DSR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

FILE: src/nearest_neighbor_image_scaler_top.sv
// Top level of the nearest-neighbor image scaler: config registers,
// sequencer and output register. Depends on nnis_pkg, nnis_div, nnis_ram.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser mode; tdata x, y, pixel
//  m_*      | out       | m_tvalid/m_tready  | tuser inside_res; tdata pixel_out,
//           |           |                    |   out_width, out_height
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load accepts the item, then writes it to the store. A fetch accepts the item,
// passes through the shared bit-serial divider for x and then for y, reads the
// store and loads the output register, in states DIVX, DIVY, READ and RESULT.
// s_tready is high only while idle; a waiting result holds the sequencer in its
// last state only. rst restores config to 256, 256, 1.0, 3 bytes; the frame
// store has no reset.

module nearest_neighbor_image_scaler_top #(
  parameter int MAX_WIDTH  = nnis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nnis_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [55:0]                        s_tdata,   // x[11:0], y[23:12], pixel[55:24]
  input  logic                               s_tuser,   // mode
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [55:0]                        m_tdata,   // pixel_out[31:0], out_width[43:32],
                                                        // out_height[55:44]
  output logic                               m_tuser,   // inside_res
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import nnis_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PROD_W = SIZE_W + SCALE_W;
  localparam int OSZ_W  = PROD_W - FRAC_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_DIVX   = 3'd2;
  localparam logic [2:0] ST_DIVY   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  // config registers, raw as written
  logic [SIZE_W-1:0]  src_width;
  logic [SIZE_W-1:0]  src_height;
  logic [SCALE_W-1:0] scale_q8;
  logic [BPP_W-1:0]   bytes_per_pixel;

  // held (clamped) views
  logic [SIZE_W-1:0]  w_h;
  logic [SIZE_W-1:0]  h_h;
  logic [SCALE_W-1:0] s_h;
  logic [BPP_W-1:0]   bpp_h;
  logic [PIX_W-1:0]   mask;

  logic [2:0]         state;
  logic               s_acc;

  // latched item
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [PIX_W-1:0]   pix_r;
  logic [OSZ_W-1:0]   ow_r;
  logic [OSZ_W-1:0]   oh_r;
  logic [DVD_W-1:0]   sx_r;
  logic               inside_r;

  logic [PROD_W-1:0]  ow_prod;
  logic [PROD_W-1:0]  oh_prod;
  logic               inside_c;

  // frame store ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [PIX_W-1:0]   ram_rdata;
  logic [31:0]        waddr_full;
  logic [31:0]        raddr_full;

  div_req_t           dreq;
  div_rsp_t           drsp;

  // output register
  logic               out_valid;
  logic [PIX_W-1:0]   out_pixel;
  logic               out_inside;
  logic [COORD_W-1:0] out_w;
  logic [COORD_W-1:0] out_h;
  logic               out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= SIZE_W'(256);
      src_height      <= SIZE_W'(256);
      scale_q8        <= SCALE_W'(256);
      bytes_per_pixel <= BPP_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width       <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height      <= cfg_data[SIZE_W-1:0];
        REG_SCALE:      scale_q8        <= cfg_data[SCALE_W-1:0];
        REG_BPP:        bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable ranges
  always_comb begin
    if (src_width == '0) begin
      w_h = SIZE_W'(1);
    end else if (int'(src_width) > MAX_WIDTH) begin
      w_h = SIZE_W'(MAX_WIDTH);
    end else begin
      w_h = src_width;
    end
    if (src_height == '0) begin
      h_h = SIZE_W'(1);
    end else if (int'(src_height) > MAX_HEIGHT) begin
      h_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_h = src_height;
    end
    if (int'(scale_q8) < SCALE_MIN) begin
      s_h = SCALE_W'(SCALE_MIN);
    end else if (int'(scale_q8) > SCALE_MAX) begin
      s_h = SCALE_W'(SCALE_MAX);
    end else begin
      s_h = scale_q8;
    end
    if (bytes_per_pixel == '0) begin
      bpp_h = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(4)) begin
      bpp_h = BPP_W'(4);
    end else begin
      bpp_h = bytes_per_pixel;
    end
    case (bpp_h)
      BPP_W'(2): mask = 32'h0000_FFFF;
      BPP_W'(3): mask = 32'h00FF_FFFF;
      BPP_W'(4): mask = 32'hFFFF_FFFF;
      default:   mask = 32'h0000_00FF;
    endcase
  end

  assign ow_prod = PROD_W'(w_h) * PROD_W'(s_h);
  assign oh_prod = PROD_W'(h_h) * PROD_W'(s_h);

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // divider requests: x at accept, y when x is done
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = {s_tdata[11:0], FRAC_W'(0)};
    dreq.divisor  = s_h;
    if (state == ST_IDLE) begin
      dreq.start = s_acc && s_tuser;
    end else if (state == ST_DIVX) begin
      dreq.start    = drsp.done;
      dreq.dividend = {y_r, FRAC_W'(0)};
    end
  end

  nnis_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // store address is row * MAX_WIDTH + column
  assign waddr_full = 32'(y_r) * 32'(MAX_WIDTH) + 32'(x_r);
  assign raddr_full = 32'(drsp.quotient[COORD_W-1:0]) * 32'(MAX_WIDTH)
                    + 32'(sx_r[COORD_W-1:0]);
  assign ram_waddr  = waddr_full[AW-1:0];
  assign ram_raddr  = raddr_full[AW-1:0];
  assign ram_we     = (state == ST_LOAD) && (x_r < COORD_W'(w_h)) && (y_r < COORD_W'(h_h));

  // in DIVY, the divider output holds sy once done
  assign inside_c = (OSZ_W'(x_r) < ow_r) && (OSZ_W'(y_r) < oh_r)
                 && (sx_r < DVD_W'(w_h)) && (drsp.quotient < DVD_W'(h_h));
  assign ram_re   = (state == ST_DIVY) && drsp.done && inside_c;

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pix_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_load = (state == ST_RESULT) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            state <= s_tuser ? ST_DIVX : ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_DIVX: begin
          if (drsp.done) begin
            state <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (drsp.done) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_RESULT;  // read data lands this cycle
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      x_r   <= s_tdata[11:0];
      y_r   <= s_tdata[23:12];
      pix_r <= s_tdata[55:24];
      ow_r  <= ow_prod[PROD_W-1:FRAC_W];
      oh_r  <= oh_prod[PROD_W-1:FRAC_W];
    end
    if ((state == ST_DIVX) && drsp.done) begin
      sx_r <= drsp.quotient;
    end
    if ((state == ST_DIVY) && drsp.done) begin
      inside_r <= inside_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel  <= inside_r ? (ram_rdata & mask) : '0;
      out_inside <= inside_r;
      out_w      <= (int'(ow_r) > SIZE_SAT) ? COORD_W'(SIZE_SAT) : COORD_W'(ow_r);
      out_h      <= (int'(oh_r) > SIZE_SAT) ? COORD_W'(SIZE_SAT) : COORD_W'(oh_r);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_h, out_w, out_pixel};
  assign m_tuser  = out_inside;

endmodule
